FILE: design/qsc_pkg.sv
package qsc_pkg;

  // coordinate width of the input fields and default working width
  localparam int unsigned IN_W                = 12;
  localparam int unsigned COORD_BITS_DEFAULT  = 12;

  localparam int unsigned CORNERS    = 4;
  localparam int unsigned MIN_AREA_W = 24;
  localparam int unsigned COS_LIM_W  = 17;
  localparam int unsigned AREA_W     = 25;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned Q_FRAC     = 16;

  // register stages inside a corner lane and the matching area path
  localparam int unsigned LANE_LAT = 5;

  localparam logic [MIN_AREA_W-1:0] MIN_AREA_RST = MIN_AREA_W'(100);
  localparam logic [COS_LIM_W-1:0]  COS_LIM_RST  = COS_LIM_W'(10486);
  localparam logic [AREA_W-1:0]     AREA_MAX     = {AREA_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_AREA = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COS_LIM  = 1'b1;

  typedef enum logic [1:0] {
    CAUSE_OK     = 2'd0,
    CAUSE_AREA   = 2'd1,
    CAUSE_CONVEX = 2'd2,
    CAUSE_ANGLE  = 2'd3
  } qsc_cause_e;

  typedef struct packed {
    logic [IN_W-1:0] corner0_x;
    logic [IN_W-1:0] corner0_y;
    logic [IN_W-1:0] corner1_x;
    logic [IN_W-1:0] corner1_y;
    logic [IN_W-1:0] corner2_x;
    logic [IN_W-1:0] corner2_y;
    logic [IN_W-1:0] corner3_x;
    logic [IN_W-1:0] corner3_y;
  } qsc_in_t;

  typedef struct packed {
    logic              is_quad;
    qsc_cause_e        reject_cause;
    logic [AREA_W-1:0] double_area;
  } qsc_out_t;

  // what one corner lane reports to the merge stage
  typedef struct packed {
    logic turn_pos;
    logic turn_neg;
    logic angle_bad;
  } qsc_lane_t;

  // what the area path reports to the merge stage
  typedef struct packed {
    logic              too_small;
    logic [AREA_W-1:0] double_area;
  } qsc_area_t;

endpackage

FILE: design/qsc_corner_lane.sv
module qsc_corner_lane
  import qsc_pkg::*;
#(
  parameter int unsigned CW = COORD_BITS_DEFAULT
) (
  input  logic                 clk_i,
  input  logic [CW-1:0]        prev_x_i,
  input  logic [CW-1:0]        prev_y_i,
  input  logic [CW-1:0]        cur_x_i,
  input  logic [CW-1:0]        cur_y_i,
  input  logic [CW-1:0]        next_x_i,
  input  logic [CW-1:0]        next_y_i,
  input  logic [COS_LIM_W-1:0] cos_lim_i,
  output qsc_lane_t            flags_o
);

  localparam int unsigned PW  = 2 * CW + 2;
  localparam int unsigned DW  = PW + 1;
  localparam int unsigned LW  = 2 * CW + 1;
  localparam int unsigned SQW = 4 * CW + 2;
  localparam int unsigned HW  = LW + COS_LIM_W;
  localparam int unsigned RW  = 2 * LW + COS_LIM_W;

  // edge vectors leaving the corner: u towards next, v towards prev
  logic signed [CW:0] ux, uy, vx, vy;

  assign ux = $signed({1'b0, next_x_i}) - $signed({1'b0, cur_x_i});
  assign uy = $signed({1'b0, next_y_i}) - $signed({1'b0, cur_y_i});
  assign vx = $signed({1'b0, prev_x_i}) - $signed({1'b0, cur_x_i});
  assign vy = $signed({1'b0, prev_y_i}) - $signed({1'b0, cur_y_i});

  // stage a: element products
  logic signed [PW-1:0] uxvx_q, uyvy_q, uxux_q, uyuy_q, vxvx_q, vyvy_q, uxvy_q, vxuy_q;

  always_ff @(posedge clk_i) begin
    uxvx_q <= ux * vx;
    uyvy_q <= uy * vy;
    uxux_q <= ux * ux;
    uyuy_q <= uy * uy;
    vxvx_q <= vx * vx;
    vyvy_q <= vy * vy;
    uxvy_q <= ux * vy;
    vxuy_q <= vx * uy;
  end

  // stage b: dot product, squared lengths, turn sign
  logic signed [DW-1:0] dot_d, lu_d, lv_d, cross_d;
  logic signed [DW-1:0] dot_q;
  logic [LW-1:0]        lu_q, lv_q;
  logic                 pos_b_q, neg_b_q;

  always_comb begin
    dot_d   = DW'(uxvx_q) + DW'(uyvy_q);
    lu_d    = DW'(uxux_q) + DW'(uyuy_q);
    lv_d    = DW'(vxvx_q) + DW'(vyvy_q);
    cross_d = DW'(uxvy_q) - DW'(vxuy_q);
  end

  always_ff @(posedge clk_i) begin
    dot_q   <= dot_d;
    lu_q    <= lu_d[LW-1:0];
    lv_q    <= lv_d[LW-1:0];
    pos_b_q <= ~cross_d[DW-1] & (|cross_d);
    neg_b_q <= cross_d[DW-1];
  end

  // stage c: squared dot and length product
  logic signed [2*DW-1:0] sq_full;
  logic [SQW-1:0]         sq_c_q;
  logic [2*LW-1:0]        len_prod_q;
  logic                   pos_c_q, neg_c_q;

  assign sq_full = dot_q * dot_q;

  always_ff @(posedge clk_i) begin
    sq_c_q     <= sq_full[SQW-1:0];
    len_prod_q <= lu_q * lv_q;
    pos_c_q    <= pos_b_q;
    neg_c_q    <= neg_b_q;
  end

  // stage d: limit times length product, split in two halves
  logic [HW-1:0]  part_lo_q, part_hi_q;
  logic [SQW-1:0] sq_d_q;
  logic           pos_d_q, neg_d_q;

  always_ff @(posedge clk_i) begin
    part_lo_q <= len_prod_q[LW-1:0] * cos_lim_i;
    part_hi_q <= len_prod_q[2*LW-1:LW] * cos_lim_i;
    sq_d_q    <= sq_c_q;
    pos_d_q   <= pos_c_q;
    neg_d_q   <= neg_c_q;
  end

  // stage e: recombine and compare
  logic [RW-1:0] rhs, lhs;
  qsc_lane_t     flags_q;

  always_comb begin
    rhs = {part_hi_q, {LW{1'b0}}} + RW'(part_lo_q);
    lhs = RW'({sq_d_q, {Q_FRAC{1'b0}}});
  end

  always_ff @(posedge clk_i) begin
    flags_q.turn_pos  <= pos_d_q;
    flags_q.turn_neg  <= neg_d_q;
    flags_q.angle_bad <= lhs > rhs;
  end

  assign flags_o = flags_q;

endmodule

FILE: design/qsc_area.sv
module qsc_area
  import qsc_pkg::*;
#(
  parameter int unsigned CW = COORD_BITS_DEFAULT
) (
  input  logic                  clk_i,
  input  logic [CW-1:0]         x_i [CORNERS],
  input  logic [CW-1:0]         y_i [CORNERS],
  input  logic [MIN_AREA_W-1:0] min_area_i,
  output qsc_area_t             area_o
);

  localparam int unsigned PW = 2 * CW + 2;
  localparam int unsigned DW = PW + 1;
  localparam int unsigned MW = 2 * CW + 1;
  localparam int unsigned EW = (MW > AREA_W) ? MW : AREA_W;

  // shoelace sum of a quadrilateral from its two diagonals
  logic signed [CW:0] d02x, d13y, d13x, d02y;

  assign d02x = $signed({1'b0, x_i[0]}) - $signed({1'b0, x_i[2]});
  assign d13y = $signed({1'b0, y_i[1]}) - $signed({1'b0, y_i[3]});
  assign d13x = $signed({1'b0, x_i[1]}) - $signed({1'b0, x_i[3]});
  assign d02y = $signed({1'b0, y_i[0]}) - $signed({1'b0, y_i[2]});

  logic signed [PW-1:0] prod_a_q, prod_b_q;

  always_ff @(posedge clk_i) begin
    prod_a_q <= d02x * d13y;
    prod_b_q <= d13x * d02y;
  end

  logic signed [DW-1:0] sum_q;

  always_ff @(posedge clk_i) begin
    sum_q <= DW'(prod_a_q) - DW'(prod_b_q);
  end

  logic signed [DW-1:0] neg_sum;
  logic [MW-1:0]        mag_q;

  assign neg_sum = -sum_q;

  always_ff @(posedge clk_i) begin
    mag_q <= sum_q[DW-1] ? neg_sum[MW-1:0] : sum_q[MW-1:0];
  end

  logic [EW-1:0] mag_e, thresh_e;
  qsc_area_t     area_d_q, area_e_q;

  always_comb begin
    mag_e    = EW'(mag_q);
    thresh_e = EW'({min_area_i, 1'b0});
  end

  always_ff @(posedge clk_i) begin
    area_d_q.too_small   <= mag_e < thresh_e;
    area_d_q.double_area <= (mag_e > EW'(AREA_MAX)) ? AREA_MAX : mag_e[AREA_W-1:0];
    // line up with the corner lanes
    area_e_q             <= area_d_q;
  end

  assign area_o = area_e_q;

endmodule

FILE: design/qsc_merge.sv
module qsc_merge
  import qsc_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  qsc_area_t                 area_i,
  input  qsc_lane_t [CORNERS-1:0]   lane_i,
  output logic                      valid_o,
  output qsc_out_t                  result_o
);

  logic       any_pos, any_neg, any_angle;
  qsc_cause_e cause;
  logic       valid_q;
  qsc_out_t   result_q;

  always_comb begin
    any_pos   = 1'b0;
    any_neg   = 1'b0;
    for (int i = 0; i < CORNERS; i++) begin
      any_pos = any_pos | lane_i[i].turn_pos;
      any_neg = any_neg | lane_i[i].turn_neg;
    end
    // corner 0 takes no part in the angle test
    any_angle = lane_i[1].angle_bad | lane_i[2].angle_bad | lane_i[3].angle_bad;

    if (area_i.too_small) begin
      cause = CAUSE_AREA;
    end else if (any_pos && any_neg) begin
      cause = CAUSE_CONVEX;
    end else if (any_angle) begin
      cause = CAUSE_ANGLE;
    end else begin
      cause = CAUSE_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q.is_quad      <= (cause == CAUSE_OK);
    result_q.reject_cause <= cause;
    result_q.double_area  <= area_i.double_area;
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

FILE: design/quad_shape_classifier_core.sv
// Near-rectangle test for one quadrilateral given as four pixel corners. A
// transfer is taken on every clock edge with start high and busy low; busy is
// only high in the first cycle after reset, so one quadrilateral is accepted
// every cycle. Each result appears on result_o for a single cycle, marked by
// done_o; the receiver cannot stall it, so it must take every strobe. A
// transfer passes the input register, then the corner lane stages: edge
// products, dot and length sums, the squared dot and length product, the
// limit product split in two halves, and the final compare, then one merge
// register. Four lanes run side by side, one per corner. Configuration
// writes (minimum area, squared cosine limit) are always ready and must only
// be made with no quadrilateral in flight.
module quad_shape_classifier_core
  import qsc_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  qsc_in_t               quad_i,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  done_o,
  output qsc_out_t              result_o
);

  localparam int unsigned KEEP = (COORD_BITS < IN_W) ? COORD_BITS : IN_W;

  // configuration registers
  logic [MIN_AREA_W-1:0] min_area_q;
  logic [COS_LIM_W-1:0]  cos_lim_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_area_q <= MIN_AREA_RST;
      cos_lim_q  <= COS_LIM_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_MIN_AREA: min_area_q <= cfg_data_i[MIN_AREA_W-1:0];
        CFG_COS_LIM:  cos_lim_q  <= cfg_data_i[COS_LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // busy only while coming out of reset
  logic busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  assign busy = busy_q;

  logic accept;
  assign accept = start & ~busy_q;

  // valid bits alongside the input register and the lane stages
  logic [LANE_LAT:0] vld_d, vld_q;

  assign vld_d = {vld_q[LANE_LAT-1:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // input register, coordinates cut to the working width
  logic [IN_W-1:0]       raw_x [CORNERS];
  logic [IN_W-1:0]       raw_y [CORNERS];
  logic [COORD_BITS-1:0] cx_d [CORNERS];
  logic [COORD_BITS-1:0] cy_d [CORNERS];
  logic [COORD_BITS-1:0] cx_q [CORNERS];
  logic [COORD_BITS-1:0] cy_q [CORNERS];

  always_comb begin
    raw_x[0] = quad_i.corner0_x;
    raw_y[0] = quad_i.corner0_y;
    raw_x[1] = quad_i.corner1_x;
    raw_y[1] = quad_i.corner1_y;
    raw_x[2] = quad_i.corner2_x;
    raw_y[2] = quad_i.corner2_y;
    raw_x[3] = quad_i.corner3_x;
    raw_y[3] = quad_i.corner3_y;
    for (int i = 0; i < CORNERS; i++) begin
      cx_d[i]         = '0;
      cy_d[i]         = '0;
      cx_d[i][KEEP-1:0] = raw_x[i][KEEP-1:0];
      cy_d[i][KEEP-1:0] = raw_y[i][KEEP-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cx_q <= cx_d;
      cy_q <= cy_d;
    end
  end

  // one lane per corner
  qsc_lane_t [CORNERS-1:0] lane_flags;

  for (genvar g = 0; g < CORNERS; g++) begin : g_lane
    qsc_corner_lane #(
      .CW (COORD_BITS)
    ) u_lane (
      .clk_i     (clk_i),
      .prev_x_i  (cx_q[(g + CORNERS - 1) % CORNERS]),
      .prev_y_i  (cy_q[(g + CORNERS - 1) % CORNERS]),
      .cur_x_i   (cx_q[g]),
      .cur_y_i   (cy_q[g]),
      .next_x_i  (cx_q[(g + 1) % CORNERS]),
      .next_y_i  (cy_q[(g + 1) % CORNERS]),
      .cos_lim_i (cos_lim_q),
      .flags_o   (lane_flags[g])
    );
  end

  qsc_area_t area_res;

  qsc_area #(
    .CW (COORD_BITS)
  ) u_area (
    .clk_i      (clk_i),
    .x_i        (cx_q),
    .y_i        (cy_q),
    .min_area_i (min_area_q),
    .area_o     (area_res)
  );

  qsc_merge u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (vld_q[LANE_LAT]),
    .area_i   (area_res),
    .lane_i   (lane_flags),
    .valid_o  (done_o),
    .result_o (result_o)
  );

`ifndef NO_ASSERTIONS
  localparam int unsigned TOTAL_LAT = LANE_LAT + 2;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##TOTAL_LAT done_o)
    else $error("transfer without a result strobe");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, TOTAL_LAT))
    else $error("result strobe without a matching transfer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.is_quad == (result_o.reject_cause == CAUSE_OK)))
    else $error("pass flag disagrees with reject cause");
`endif

endmodule
